FILE: rtl/pla_pkg.sv
// Package for the priority lock arbiter: sizes, queue cell types, status and mode codes.
// Used by pla_cell and priority_lock_arbiter_core. No dependencies.

package pla_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int PRI_BITS    = 3;
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    localparam logic MODE_ACQUIRE = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        ST_GRANTED = 3'd0,
        ST_BUSY    = 3'd1,
        ST_QUEUED  = 3'd2,
        ST_FULL    = 3'd3,
        ST_HANDED  = 3'd4,
        ST_FREED   = 3'd5
    } t_status;

    typedef struct packed {
        logic                valid;
        logic [ID_BITS-1:0]  id;
        logic [PRI_BITS-1:0] pri;
    } t_entry;

    // broadcast to every cell for one transfer
    typedef struct packed {
        logic                insert;
        logic                remove;
        logic [ID_BITS-1:0]  id;
        logic [PRI_BITS-1:0] pri;
    } t_cell_ctl;

endpackage

FILE: rtl/priority_lock_arbiter_core.sv
// Priority lock arbiter top level: lock owner, waiter count, output register, cell row.
// Depends on pla_pkg and pla_cell.
//
// Usage:
//   Slave channel (i_s_*) carries one operation per transfer: tuser selects acquire
//   or release, tdata holds requester id, priority and the may-wait flag.
//   Master channel (o_m_*) returns exactly one result per operation: status,
//   owner after the operation and the number of waiters.
//   The result is registered and appears in the cycle after the input transfer.
//   Throughput: one operation per cycle while the receiver is ready. The wait queue is
//   a row of cells kept sorted by priority (earliest first among equals), so the best waiter
//   always sits in the head cell and each insert or removal is a single shift step.
//   Reset (synchronous, active low) frees the lock and empties the queue; the
//   block is ready in the first cycle after reset.
//   When the receiver stalls, the result is held in the output register and the
//   slave channel is not ready until that result is transferred, or in the same
//   cycle as it is.

module priority_lock_arbiter_core
    import pla_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] requester_id, [10:8] req_priority,
                                     // [11] may_wait, [15:12] zero
    input  logic        i_s_tuser,   // [0] mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // [2:0] status, [10:3] owner_id, [15:11] queue_count
);

    logic [ID_BITS-1:0]  r_owner;
    logic [ID_BITS-1:0]  n_owner;
    logic [CNT_BITS-1:0] r_count;
    logic [CNT_BITS-1:0] n_count;
    logic                r_out_valid;
    t_status             r_status;
    t_status             n_status;
    logic [ID_BITS-1:0]  r_out_owner;
    logic [CNT_BITS-1:0] r_out_count;

    logic                in_xfer;
    logic [ID_BITS-1:0]  in_id;
    logic [PRI_BITS-1:0] in_pri;
    logic                in_wait;
    t_cell_ctl           cell_ctl;

    t_entry cell_entry [QUEUE_DEPTH];
    logic   cell_keep  [QUEUE_DEPTH];

    assign in_id   = i_s_tdata[ID_BITS-1:0];
    assign in_pri  = i_s_tdata[ID_BITS+PRI_BITS-1:ID_BITS];
    assign in_wait = i_s_tdata[ID_BITS+PRI_BITS];

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign in_xfer    = i_s_tvalid && o_s_tready;

    always_comb begin
        n_owner         = r_owner;
        n_count         = r_count;
        n_status        = ST_BUSY;
        cell_ctl.insert = 1'b0;
        cell_ctl.remove = 1'b0;
        cell_ctl.id     = in_id;
        cell_ctl.pri    = in_pri;
        if (i_s_tuser == MODE_ACQUIRE) begin
            if (in_id == '0) begin
                n_status = ST_BUSY;
            end else if (r_owner == '0 || r_owner == in_id) begin
                n_owner  = in_id;
                n_status = ST_GRANTED;
            end else if (!in_wait) begin
                n_status = ST_BUSY;
            end else if (r_count == CNT_BITS'(QUEUE_DEPTH)) begin
                n_status = ST_FULL;
            end else begin
                cell_ctl.insert = in_xfer;
                n_count         = r_count + 1'b1;
                n_status        = ST_QUEUED;
            end
        end else begin
            if (r_count == '0) begin
                n_owner  = '0;
                n_status = ST_FREED;
            end else begin
                cell_ctl.remove = in_xfer;
                n_owner         = cell_entry[0].id;
                n_count         = r_count - 1'b1;
                n_status        = ST_HANDED;
            end
        end
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry prev_entry;
        logic   prev_keep;
        t_entry next_entry;

        if (g == 0) begin : g_head
            assign prev_entry = '0;
            assign prev_keep  = 1'b1;
        end else begin : g_body
            assign prev_entry = cell_entry[g-1];
            assign prev_keep  = cell_keep[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign next_entry = '0;
        end else begin : g_inner
            assign next_entry = cell_entry[g+1];
        end

        pla_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (cell_ctl),
            .i_prev      (prev_entry),
            .i_prev_keep (prev_keep),
            .i_next      (next_entry),
            .o_entry     (cell_entry[g]),
            .o_keep      (cell_keep[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_owner     <= n_owner;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_status    <= n_status;
            r_out_owner <= n_owner;
            r_out_count <= n_count;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = 16'({r_out_count, r_out_owner, r_status});

endmodule

FILE: rtl/pla_cell.sv
// One slot of the priority-sorted wait queue.
// Depends on pla_pkg. Shifts toward the tail on insert, toward the head on remove.

module pla_cell
    import pla_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_prev,       // neighbor toward the head
    input  logic      i_prev_keep,  // neighbor toward the head holds its entry
    input  t_entry    i_next,       // neighbor toward the tail
    output t_entry    o_entry,
    output logic      o_keep
);

    logic                r_valid;
    logic [ID_BITS-1:0]  r_id;
    logic [PRI_BITS-1:0] r_pri;
    t_entry              n_entry;

    // equal priority stays ahead of the newcomer: arrival order among equals
    assign o_keep  = r_valid && (r_pri >= i_ctl.pri);
    assign o_entry = '{valid: r_valid, id: r_id, pri: r_pri};

    always_comb begin
        n_entry = o_entry;
        if (i_ctl.insert) begin
            if (!o_keep) begin
                if (i_prev_keep) begin
                    n_entry = '{valid: 1'b1, id: i_ctl.id, pri: i_ctl.pri};
                end else begin
                    n_entry = i_prev;
                end
            end
        end else if (i_ctl.remove) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id  <= n_entry.id;
        r_pri <= n_entry.pri;
    end

endmodule

FILE: tb/priority_lock_arbiter_core_tb.sv
`timescale 1ns / 1ps
// Testbench for priority_lock_arbiter_core: directed and random lock traffic, with results
// checked against a transaction-level model of the lock owner and its priority wait queue.
// Depends on pla_pkg and the priority_lock_arbiter_core RTL.

import pla_pkg::*;

typedef struct {
    logic [ID_BITS-1:0]  id;
    logic [PRI_BITS-1:0] pri;
} t_waiter;

typedef struct {
    t_status             status;
    logic [ID_BITS-1:0]  owner;
    logic [CNT_BITS-1:0] count;
} t_lock_result;

class lock_scoreboard;
    logic [ID_BITS-1:0] owner;
    t_waiter            waiters[$];     // arrival order
    t_lock_result       expected_q[$];
    int                 errors;

    function new();
        owner  = '0;
        errors = 0;
    endfunction

    // Applies one accepted operation to the lock model and queues the result it causes.
    function void note_op(logic mode, logic [ID_BITS-1:0] id, logic [PRI_BITS-1:0] pri,
                          logic may_wait);
        t_lock_result r;
        t_waiter      w;
        int           best;
        if (mode == MODE_ACQUIRE) begin
            if (id == '0) begin
                r.status = ST_BUSY;
            end else if (owner == '0 || owner == id) begin
                owner    = id;
                r.status = ST_GRANTED;
            end else if (!may_wait) begin
                r.status = ST_BUSY;
            end else if (waiters.size() >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                w.id  = id;
                w.pri = pri;
                waiters.insert(waiters.size(), w);
                r.status = ST_QUEUED;
            end
        end else if (waiters.size() == 0) begin
            owner    = '0;
            r.status = ST_FREED;
        end else begin
            // strict compare keeps the earliest arrival among equal priorities
            best = 0;
            for (int i = 1; i < waiters.size(); i++)
                if (waiters[i].pri > waiters[best].pri)
                    best = i;
            owner = waiters[best].id;
            waiters.delete(best);
            r.status = ST_HANDED;
        end
        r.owner = owner;
        r.count = CNT_BITS'(waiters.size());
        expected_q.insert(expected_q.size(), r);
    endfunction

    // Compares one result transfer with the oldest expected result.
    function void check_result(logic [15:0] tdata);
        t_lock_result r;
        if (expected_q.size() == 0) begin
            $error("unexpected result transfer, tdata 0x%04h", tdata);
            errors++;
            return;
        end
        r = expected_q.pop_front();
        if (tdata[2:0] !== r.status) begin
            $error("status: expected %0d, actual %0d", r.status, tdata[2:0]);
            errors++;
        end
        if (tdata[10:3] !== r.owner) begin
            $error("owner_id: expected %0d, actual %0d", r.owner, tdata[10:3]);
            errors++;
        end
        if (tdata[15:11] !== r.count) begin
            $error("queue_count: expected %0d, actual %0d", r.count, tdata[15:11]);
            errors++;
        end
    endfunction
endclass

module priority_lock_arbiter_core_tb;

    localparam int IDLE_LIMIT = 1000;
    localparam int RANDOM_OPS = 600;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata  = '0;     // [7:0] requester_id, [10:8] req_priority, [11] may_wait
    logic        s_tuser  = 1'b0;   // [0] mode
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;           // [2:0] status, [10:3] owner_id, [15:11] queue_count
    int          idle_cycles = 0;

    lock_scoreboard sb = new();

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    priority_lock_arbiter_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Biased toward the current owner and queued ids so reacquire and duplicates show up.
    function automatic logic [ID_BITS-1:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return '0;
        if (r < 13 && sb.owner != '0)
            return sb.owner;
        if (r < 23 && sb.waiters.size() > 0)
            return sb.waiters[$urandom_range(0, sb.waiters.size() - 1)].id;
        return ID_BITS'($urandom_range(1, 255));
    endfunction

    task automatic send_lock_op(input logic mode, input logic [ID_BITS-1:0] id,
                                input logic [PRI_BITS-1:0] pri, input logic may_wait,
                                input bit no_gap);
        int gap;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'b0, may_wait, pri, id};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.note_op(mode, id, pri, may_wait);
    endtask

    // result side backpressure
    initial begin
        int stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = ($urandom_range(0, 9) == 0) ? 0 : pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(60, 200)) @(posedge i_clk);
            else
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // watchdog: ends the run after too many cycles without any transfer
    initial begin
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("priority_lock_arbiter_core: mismatch");
        $finish;
    end

    initial begin
        int                  acq_pct;
        bit                  quiet;
        logic [PRI_BITS-1:0] pri;
        acq_pct = 60;
        quiet   = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_lock_op(MODE_RELEASE, 8'd0, 3'd0, 1'b0, 0);    // release while free
        send_lock_op(MODE_ACQUIRE, 8'd0, 3'd7, 1'b1, 0);    // zero id is refused
        send_lock_op(MODE_ACQUIRE, 8'd1, 3'd0, 1'b0, 0);
        send_lock_op(MODE_ACQUIRE, 8'd1, 3'd7, 1'b1, 0);    // owner reacquires
        send_lock_op(MODE_ACQUIRE, 8'd255, 3'd7, 1'b0, 0);  // busy, won't wait
        // fill the queue: duplicate ids, tied top priorities, all priority values
        for (int k = 0; k < QUEUE_DEPTH; k++)
            send_lock_op(MODE_ACQUIRE, (k % 5 == 4) ? 8'd255 : 8'(16 + k),
                         3'((k * 3) % 8), 1'b1, 0);
        send_lock_op(MODE_ACQUIRE, 8'd200, 3'd7, 1'b1, 0);  // queue full
        send_lock_op(MODE_RELEASE, 8'd170, 3'd5, 1'b1, 0);  // release by a non-owner
        send_lock_op(MODE_RELEASE, 8'd85, 3'd2, 1'b0, 0);

        for (int n = 0; n < RANDOM_OPS; n++) begin
            // phases that fill the queue, hover, or drain it
            if (n % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: acq_pct = 35;
                    1: acq_pct = 60;
                    default: acq_pct = 90;
                endcase
                quiet = ($urandom_range(0, 3) == 0);
            end
            pri = PRI_BITS'($urandom_range(0, 7));
            if ($urandom_range(0, 99) < acq_pct)
                send_lock_op(MODE_ACQUIRE, pick_id(), pri, $urandom_range(0, 99) < 85, quiet);
            else
                send_lock_op(MODE_RELEASE, ID_BITS'($urandom()), pri,
                             1'($urandom_range(0, 1)), quiet);
        end
        s_tvalid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0)
            $display("priority_lock_arbiter_core: match");
        else
            $display("priority_lock_arbiter_core: mismatch");
        $finish;
    end

endmodule
